[src/lrps_pkg.sv]
// ---------------------------------------------------------------------------
// lrps_pkg: shared types and constants for the LED row pulse serializer
// Beat payloads, the front-to-back command word, phase codes, register map.
// ---------------------------------------------------------------------------
package lrps_pkg;

  localparam int PIXELS_PER_ROW = 8;
  localparam int COUNTER_WIDTH  = 16;
  localparam int CMP_W          = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
  localparam int BITS_PER_PIXEL = 24;

  localparam logic [2:0] PIX_LAST = 3'(PIXELS_PER_ROW - 1);
  localparam logic [4:0] BIT_LAST = 5'(BITS_PER_PIXEL - 1);

  typedef enum logic [2:0] {
    REG_RED       = 3'd0,
    REG_GREEN     = 3'd1,
    REG_BLUE      = 3'd2,
    REG_ONE_HIGH  = 3'd3,
    REG_ONE_LOW   = 3'd4,
    REG_ZERO_HIGH = 3'd5,
    REG_ZERO_LOW  = 3'd6,
    REG_GAP       = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_PUSH = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] row_bits;
    logic       row_odd;
    logic       last_row;
  } in_item_t;

  typedef struct packed {
    logic data_out;
    logic busy_res;
    logic rejected;
  } out_item_t;

  // Row bits are already in send order: bit 0 goes out first.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] row;
    logic       gap;
  } cmd_t;

endpackage

[src/lrps_front.sv]
// ---------------------------------------------------------------------------
// lrps_front: input side of the LED row pulse serializer
// Classify each input beat into a command, put the row in send order and
// hold commands in a two-entry queue for the waveform engine.
// ---------------------------------------------------------------------------
module lrps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrps_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output lrps_pkg::cmd_t    q_cmd
);
  import lrps_pkg::*;

  cmd_t       entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;
  logic [7:0] ordered;

  // Odd rows go out MSB first: reverse them so the engine always walks up.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ordered[i] = in_data.row_odd ? in_data.row_bits[7 - i] : in_data.row_bits[i];
    end
    cmd_in.kind = in_data.action ? CMD_PUSH : CMD_TICK;
    cmd_in.row  = ordered;
    cmd_in.gap  = in_data.last_row;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[src/lrps_back.sv]
// ---------------------------------------------------------------------------
// lrps_back: waveform engine of the LED row pulse serializer
// Execute one queued command per cycle unless the output stalls, keep the
// pulse timing state and the configuration registers, and register each result.
// ---------------------------------------------------------------------------
module lrps_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  output logic               q_pop,
  input  lrps_pkg::cmd_t     q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output lrps_pkg::out_item_t out_data
);
  import lrps_pkg::*;

  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic [11:0] one_high_ticks;
  logic [11:0] one_low_ticks;
  logic [11:0] zero_high_ticks;
  logic [11:0] zero_low_ticks;
  logic [15:0] gap_ticks;

  phase_t                   phase;
  phase_t                   phase_next;
  logic [7:0]               row;
  logic [7:0]               row_next;
  logic                     gap_pending;
  logic                     gap_pending_next;
  logic [2:0]               pix;
  logic [2:0]               pix_next;
  logic [4:0]               bit_idx;
  logic [4:0]               bit_idx_next;
  logic [COUNTER_WIDTH-1:0] cnt;
  logic [COUNTER_WIDTH-1:0] cnt_next;

  logic [COUNTER_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]         len;
  logic                     done;
  logic [7:0]               colour;
  logic                     cur_bit;
  logic                     busy;
  out_item_t                res;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign busy  = (phase != PH_IDLE);

  // Level of the bit being sent: black pixels send zeros.
  always_comb begin
    if (bit_idx < 5'd8) begin
      colour = green_level;
    end else if (bit_idx < 5'd16) begin
      colour = red_level;
    end else begin
      colour = blue_level;
    end
    cur_bit = row[pix] && colour[3'd7 - bit_idx[2:0]];
  end

  always_comb begin
    unique case (phase)
      PH_HIGH: len = CMP_W'(cur_bit ? one_high_ticks : zero_high_ticks);
      PH_LOW:  len = CMP_W'(cur_bit ? one_low_ticks : zero_low_ticks);
      PH_GAP:  len = CMP_W'(gap_ticks);
      default: len = '0;
    endcase
    cnt_inc = cnt + COUNTER_WIDTH'(1);
    done    = (CMP_W'(cnt_inc) >= len) || (cnt_inc == '1);
  end

  always_comb begin
    phase_next       = phase;
    row_next         = row;
    gap_pending_next = gap_pending;
    pix_next         = pix;
    bit_idx_next     = bit_idx;
    cnt_next         = cnt;
    res.data_out     = (phase == PH_HIGH);
    res.busy_res     = busy;
    res.rejected     = 1'b0;
    if (q_cmd.kind == CMD_PUSH) begin
      res.busy_res = 1'b1;
      res.rejected = busy;
      if (!busy) begin
        row_next         = q_cmd.row;
        gap_pending_next = q_cmd.gap;
        pix_next         = 3'd0;
        bit_idx_next     = 5'd0;
        cnt_next         = '0;
        phase_next       = PH_HIGH;
      end
    end else if (busy) begin
      cnt_next = done ? '0 : cnt_inc;
      if (done) begin
        unique case (phase)
          PH_HIGH: phase_next = PH_LOW;
          PH_LOW: begin
            if (bit_idx < BIT_LAST) begin
              bit_idx_next = bit_idx + 5'd1;
              phase_next   = PH_HIGH;
            end else begin
              bit_idx_next = 5'd0;
              if (pix < PIX_LAST) begin
                pix_next   = pix + 3'd1;
                phase_next = PH_HIGH;
              end else begin
                pix_next   = 3'd0;
                phase_next = gap_pending ? PH_GAP : PH_IDLE;
              end
            end
          end
          PH_GAP: begin
            gap_pending_next = 1'b0;
            phase_next       = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      row         <= 8'd0;
      gap_pending <= 1'b0;
      pix         <= 3'd0;
      bit_idx     <= 5'd0;
      cnt         <= '0;
    end else if (q_pop) begin
      phase       <= phase_next;
      row         <= row_next;
      gap_pending <= gap_pending_next;
      pix         <= pix_next;
      bit_idx     <= bit_idx_next;
      cnt         <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_level       <= 8'd0;
      green_level     <= 8'd0;
      blue_level      <= 8'd0;
      one_high_ticks  <= 12'd16;
      one_low_ticks   <= 12'd9;
      zero_high_ticks <= 12'd8;
      zero_low_ticks  <= 12'd17;
      gap_ticks       <= 16'd1000;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_RED:       red_level       <= cfg_data[7:0];
        REG_GREEN:     green_level     <= cfg_data[7:0];
        REG_BLUE:      blue_level      <= cfg_data[7:0];
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[11:0];
        REG_ONE_LOW:   one_low_ticks   <= cfg_data[11:0];
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[11:0];
        REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[11:0];
        REG_GAP:       gap_ticks       <= cfg_data;
        default:       gap_ticks       <= gap_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= res;
    end
  end

endmodule

[src/led_row_pulse_serializer.sv]
// ---------------------------------------------------------------------------
// led_row_pulse_serializer: NRZ pulse encoder for one row of RGB LEDs
// Input beats either push an 8-pixel row or advance the line by one tick;
// every input beat yields exactly one output beat with the line level.
//
// Usage:
//   in_*   : valid/ready channel. action 1 pushes a row (row_bits, row_odd,
//            last_row), action 0 advances the waveform one tick.
//   out_*  : valid/ready channel, one beat per input beat, in order:
//            data_out (line level for that tick), busy_res, rejected.
//   cfg_*  : write-only register port, one write per cycle, no wait. Write
//            only while the block is idle and all results have drained.
// From input beat to output beat, each command is registered in the
// command queue, then the waveform engine step loads the output
// register. Sustained rate is one beat per cycle while the receiver
// keeps taking beats.
// A push while a row or gap is still going out is dropped and flagged.
// Reset empties the queue and output register, returns to idle and loads
// the default timing registers. When the receiver stalls, the output
// register holds its beat and the two-entry command queue absorbs input
// until full, at which point in_ready drops.
// ---------------------------------------------------------------------------
module led_row_pulse_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lrps_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import lrps_pkg::*;

  // Command queue between the classifier and the waveform engine.
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Classify beats, reorder serpentine rows, queue commands.
  lrps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  // Advance the pulse timing one command per cycle unless the output stalls, and register results.
  lrps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/led_row_pulse_serializer_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_row_pulse_serializer_test: self-checking bench for the row serializer
// Drives push and tick beats through the valid/ready input channel and
// compares every output beat with a line-level predictor kept in this file.
// A short directed plan goes through reset timing, rejected pushes, masked
// and zero register values and longer pulses and gap. Random phases
// follow with fresh register settings, random rows and random stalls.
// ---------------------------------------------------------------------------
module led_row_pulse_serializer_test;
  import lrps_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_BEATS = 1500;

  // Register sets used by the directed plan.
  localparam logic [1:0] SET_NONE       = 2'd0;
  localparam logic [1:0] SET_LONG_ONES  = 2'd1;
  localparam logic [1:0] SET_LONG_ZEROS = 2'd2;

  typedef enum logic [1:0] {
    DO_BEAT,
    DO_DRAIN,
    DO_REGS
  } plan_op_t;

  typedef struct packed {
    plan_op_t   op;
    in_item_t   beat;
    logic       has_lit;
    out_item_t  lit;
    logic [1:0] regset;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  led_row_pulse_serializer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Line predictor state: the row being sent and where the waveform stands.
  logic [15:0] reg_shadow [8];
  logic [15:0] reg_plan [8];
  logic [7:0]  row_reg;
  logic        odd_reg;
  logic        gap_pend;
  logic [2:0]  pix_idx;
  logic [4:0]  bit_idx;
  phase_t      ph;
  logic [15:0] tcount;

  out_item_t pending_beats [$];
  int        sent_count;
  int        fail_count;
  int        cycle_count;
  bit        tx_idle;
  bit        rx_idle;
  bit        hold_req;

  // Directed plan. Literal results only where they are obvious: idle ticks,
  // the first beats after a push and pushes that meet a busy line.
  plan_row_t dir_plan [16] = '{
    // idle tick: line low, not busy
    '{DO_BEAT,  '{1'b0, 8'h5A, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}, SET_NONE},
    // reset timing, black row read MSB first
    '{DO_BEAT,  '{1'b1, 8'hFF, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0}, SET_NONE},
    // push during the first high pulse is dropped
    '{DO_BEAT,  '{1'b1, 8'h00, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1}, SET_NONE},
    '{DO_BEAT,  '{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0}, SET_NONE},
    '{DO_DRAIN, '0, 1'b0, '0, SET_NONE},
    // long one pulses with junk above bit 11, zero-length zero pulses, long gap
    '{DO_REGS,  '0, 1'b0, '0, SET_LONG_ONES},
    '{DO_BEAT,  '{1'b1, 8'h01, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0}, SET_NONE},
    '{DO_BEAT,  '{1'b0, 8'hC3, 1'b1, 1'b0}, 1'b0, '0, SET_NONE},
    '{DO_DRAIN, '0, 1'b0, '0, SET_NONE},
    '{DO_BEAT,  '{1'b0, 8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}, SET_NONE},
    // long zero pulses, zero-length one low pulse, zero gap
    '{DO_REGS,  '0, 1'b0, '0, SET_LONG_ZEROS},
    '{DO_BEAT,  '{1'b1, 8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0}, SET_NONE},
    '{DO_BEAT,  '{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0}, SET_NONE},
    // push during a low pulse: line low, dropped
    '{DO_BEAT,  '{1'b1, 8'hAA, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1}, SET_NONE},
    '{DO_DRAIN, '0, 1'b0, '0, SET_NONE},
    '{DO_BEAT,  '{1'b0, 8'h81, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}, SET_NONE}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Level of the bit under way: black pixels send only zeros, lit pixels
  // send green, red, blue, each MSB first.
  function automatic logic lit_bit();
    logic       lit;
    logic [7:0] colour;
    lit = odd_reg ? row_reg[3'd7 - pix_idx] : row_reg[pix_idx];
    if (bit_idx < 5'd8)
      colour = reg_shadow[REG_GREEN][7:0];
    else if (bit_idx < 5'd16)
      colour = reg_shadow[REG_RED][7:0];
    else
      colour = reg_shadow[REG_BLUE][7:0];
    return lit & colour[3'd7 - bit_idx[2:0]];
  endfunction

  // Count one tick; a zero length ends after one tick and the count never
  // runs past all ones.
  function automatic logic count_done(logic [15:0] len);
    logic [15:0] nxt;
    nxt = tcount + 16'd1;
    if (nxt >= len || nxt == 16'hFFFF) begin
      tcount = '0;
      return 1'b1;
    end
    tcount = nxt;
    return 1'b0;
  endfunction

  function automatic out_item_t line_advance(in_item_t it);
    out_item_t r;
    r.data_out = (ph == PH_HIGH);
    r.busy_res = (ph != PH_IDLE);
    r.rejected = 1'b0;
    if (it.action == CMD_PUSH) begin
      if (ph != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        row_reg  = it.row_bits;
        odd_reg  = it.row_odd;
        gap_pend = it.last_row;
        pix_idx  = '0;
        bit_idx  = '0;
        tcount   = '0;
        ph       = PH_HIGH;
      end
      r.busy_res = 1'b1;
    end else begin
      case (ph)
        PH_HIGH: begin
          if (count_done(lit_bit() ? reg_shadow[REG_ONE_HIGH] : reg_shadow[REG_ZERO_HIGH]))
            ph = PH_LOW;
        end
        PH_LOW: begin
          if (count_done(lit_bit() ? reg_shadow[REG_ONE_LOW] : reg_shadow[REG_ZERO_LOW])) begin
            // 24 bits per pixel, then the next pixel, then gap or idle
            if (bit_idx < 5'd23) begin
              bit_idx = bit_idx + 5'd1;
              ph      = PH_HIGH;
            end else begin
              bit_idx = '0;
              if (int'(pix_idx) + 1 < PIXELS_PER_ROW && pix_idx < 3'd7) begin
                pix_idx = pix_idx + 3'd1;
                ph      = PH_HIGH;
              end else begin
                pix_idx = '0;
                ph      = gap_pend ? PH_GAP : PH_IDLE;
              end
            end
          end
        end
        PH_GAP: begin
          if (count_done(reg_shadow[REG_GAP])) begin
            gap_pend = 1'b0;
            ph       = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic in_item_t rand_beat(cmd_kind_t kind);
    in_item_t it;
    it.action   = kind;
    it.row_bits = 8'($urandom);
    it.row_odd  = 1'($urandom);
    it.last_row = 1'($urandom);
    return it;
  endfunction

  // Short pulse length, sometimes zero, with junk above the 12 register bits.
  function automatic logic [15:0] short_len();
    logic [11:0] len;
    len = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 3));
    return {4'($urandom), len};
  endfunction

  // Offer one beat, wait for the handshake, then predict it. Valid is left
  // high so a back-to-back beat needs no second assignment in the same step.
  task automatic send_beat(in_item_t it, logic has_lit, out_item_t lit);
    int        gap;
    out_item_t pred;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pred = line_advance(it);
    pending_beats.push_back(has_lit ? lit : pred);
    sent_count++;
  endtask

  // Drop valid and let every expected beat come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all registers from reg_plan on consecutive cycles; the block is idle.
  task automatic program_regs();
    reg_index_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_index_t'(i);
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_plan[i];
      case (idx)
        REG_RED, REG_GREEN, REG_BLUE: reg_shadow[i] = reg_plan[i] & 16'h00FF;
        REG_GAP:                      reg_shadow[i] = reg_plan[i];
        default:                      reg_shadow[i] = reg_plan[i] & 16'h0FFF;
      endcase
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Push one random row and tick it out, with an occasional push that must
  // be dropped. With squeeze set, ask the receiver for a long hold-off while
  // beats keep coming so the input side backs up.
  task automatic run_row(bit squeeze);
    int ticks;
    send_beat(rand_beat(CMD_PUSH), 1'b0, '0);
    ticks = 0;
    while (ph != PH_IDLE) begin
      if ($urandom_range(0, 39) == 0)
        send_beat(rand_beat(CMD_PUSH), 1'b0, '0);
      else
        send_beat(rand_beat(CMD_TICK), 1'b0, '0);
      ticks++;
      if (squeeze && ticks == 40)
        hold_req = 1'b1;
    end
    // a few ticks on an idle line
    repeat ($urandom_range(0, 3)) send_beat(rand_beat(CMD_TICK), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("led_row_pulse_serializer_test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: check each output beat against the oldest expectation, then
  // draw how long to stall before taking the next one.
  // ---------------------------------------------------------------------

  initial begin
    int        stall;
    out_item_t want;
    out_ready = 1'b0;
    stall     = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected output beat: data_out %0b busy_res %0b rejected %0b",
                 out_data.data_out, out_data.busy_res, out_data.rejected);
          fail_count++;
        end else begin
          want = pending_beats.pop_front();
          if (out_data.data_out !== want.data_out) begin
            $error("data_out: expected %0b, got %0b", want.data_out, out_data.data_out);
            fail_count++;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_data.busy_res);
            fail_count++;
          end
          if (out_data.rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, out_data.rejected);
            fail_count++;
          end
        end
        stall = rx_idle ? $urandom_range(0, 14) : 0;
      end
      // long hold-off on request, counted here
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and run control
  // ---------------------------------------------------------------------

  initial begin
    int phase_no;
    int base;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    hold_req   = 1'b0;
    sent_count = 0;
    fail_count = 0;

    // Predictor starts from the reset timing and an idle line.
    reg_shadow[REG_RED]       = 16'd0;
    reg_shadow[REG_GREEN]     = 16'd0;
    reg_shadow[REG_BLUE]      = 16'd0;
    reg_shadow[REG_ONE_HIGH]  = 16'd16;
    reg_shadow[REG_ONE_LOW]   = 16'd9;
    reg_shadow[REG_ZERO_HIGH] = 16'd8;
    reg_shadow[REG_ZERO_LOW]  = 16'd17;
    reg_shadow[REG_GAP]       = 16'd1000;
    row_reg  = '0;
    odd_reg  = 1'b0;
    gap_pend = 1'b0;
    pix_idx  = '0;
    bit_idx  = '0;
    ph       = PH_IDLE;
    tcount   = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed plan, no idling: the long pulses and gap would take too long.
    foreach (dir_plan[i]) begin
      case (dir_plan[i].op)
        DO_BEAT: begin
          send_beat(dir_plan[i].beat, dir_plan[i].has_lit, dir_plan[i].lit);
        end
        DO_DRAIN: begin
          while (ph != PH_IDLE) send_beat(rand_beat(CMD_TICK), 1'b0, '0);
          drain_results();
        end
        DO_REGS: begin
          drain_results();
          if (dir_plan[i].regset == SET_LONG_ONES) begin
            // one lit pixel with two one bits: first green, last blue
            reg_plan[REG_RED]       = 16'h0000;
            reg_plan[REG_GREEN]     = 16'h0080;
            reg_plan[REG_BLUE]      = 16'h0001;
            reg_plan[REG_ONE_HIGH]  = 16'hF00C;
            reg_plan[REG_ONE_LOW]   = 16'hF007;
            reg_plan[REG_ZERO_HIGH] = 16'h0000;
            reg_plan[REG_ZERO_LOW]  = 16'h0000;
            reg_plan[REG_GAP]       = 16'h0141;
          end else begin
            // full row, one zero bit per pixel at the end of blue
            reg_plan[REG_RED]       = 16'h00FF;
            reg_plan[REG_GREEN]     = 16'hFFFF;
            reg_plan[REG_BLUE]      = 16'h00FE;
            reg_plan[REG_ONE_HIGH]  = 16'h0001;
            reg_plan[REG_ONE_LOW]   = 16'h0000;
            reg_plan[REG_ZERO_HIGH] = 16'hF00A;
            reg_plan[REG_ZERO_LOW]  = 16'hE00E;
            reg_plan[REG_GAP]       = 16'h0000;
          end
          program_regs();
        end
        default: ;
      endcase
    end

    // Random phases: new registers, then one or two rows. The first phase
    // runs flat out and squeezes the receiver.
    base     = sent_count;
    phase_no = 0;
    while (sent_count - base < RANDOM_BEATS || phase_no < 4) begin
      drain_results();
      reg_plan[REG_RED]       = 16'($urandom);
      reg_plan[REG_GREEN]     = 16'($urandom);
      reg_plan[REG_BLUE]      = 16'($urandom);
      reg_plan[REG_ONE_HIGH]  = short_len();
      reg_plan[REG_ONE_LOW]   = short_len();
      reg_plan[REG_ZERO_HIGH] = short_len();
      reg_plan[REG_ZERO_LOW]  = short_len();
      reg_plan[REG_GAP]       = 16'($urandom_range(0, 24));
      program_regs();
      tx_idle = (phase_no != 0) && ($urandom_range(0, 2) != 0);
      rx_idle = (phase_no != 0) && ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 2)) run_row(phase_no == 0);
      phase_no++;
    end

    // Hold until every beat is back, then wait a little longer for strays.
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("led_row_pulse_serializer_test passed");
    else
      $display("led_row_pulse_serializer_test failed");
    $finish;
  end

endmodule

[filelist.f]
src/lrps_pkg.sv
src/lrps_front.sv
src/lrps_back.sv
src/led_row_pulse_serializer.sv
tb/sv/led_row_pulse_serializer_test.sv
